>>> sv/lfv_pkg.sv
package lfv_pkg;

  localparam int unsigned CORDIC_STEPS = 14;

  localparam logic signed [15:0] CORDIC_ANGLE [CORDIC_STEPS] = '{
    16'sd6434, 16'sd3798, 16'sd2007, 16'sd1019, 16'sd511, 16'sd256, 16'sd128,
    16'sd64, 16'sd32, 16'sd16, 16'sd8, 16'sd4, 16'sd2, 16'sd1
  };

  localparam logic signed [17:0] PI_Q13      = 18'sd25736;
  localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
  localparam logic [14:0]        TURN_THRESH = 15'd819;
  localparam logic [14:0]        HALF_PI_MAG = 15'd12868;
  localparam logic [31:0]        NEAR_LIMIT  = 32'd131072;

  // e * 2^32 / 25736 == e * 166885 + e * 1867 / 3217, last term by reciprocal
  localparam logic [17:0]        TURN_MUL_HI   = 18'd166885;
  localparam logic [10:0]        TURN_MUL_LO   = 11'd1867;
  localparam logic [26:0]        RECIP_3217    = 27'd85445418;
  localparam int unsigned        RECIP_3217_SH = 38;

  localparam logic [31:0]        RECIP_5   = 32'hCCCC_CCCD;
  localparam int unsigned        RECIP_5_SH  = 34;
  localparam logic [31:0]        RECIP_25  = 32'h51EB_851F;
  localparam int unsigned        RECIP_25_SH = 35;

  localparam int unsigned REG_W = 18;
  localparam int unsigned SPD_W = 19;
  localparam int unsigned MAG_W = 26;

  typedef enum logic [2:0] {
    CFG_FWD_MIN  = 3'd0,
    CFG_FWD_MAX  = 3'd1,
    CFG_SIDE_MIN = 3'd2,
    CFG_SIDE_MAX = 3'd3,
    CFG_TURN_MIN = 3'd4,
    CFG_TURN_MAX = 3'd5
  } cfg_reg_e;

  typedef logic signed [SPD_W-1:0] speed_t;

  function automatic speed_t lfv_limit(input logic [MAG_W-1:0] m, input logic neg,
                                       input logic [REG_W-1:0] lo,
                                       input logic [REG_W-1:0] hi);
    logic [MAG_W-1:0] mm;
    logic [SPD_W-1:0] m19;
    mm = m;
    if (mm > MAG_W'(hi)) begin
      mm = MAG_W'(hi);
    end
    if (mm < MAG_W'(lo)) begin
      mm = MAG_W'(lo);
    end
    m19 = {1'b0, mm[REG_W-1:0]};
    return neg ? speed_t'(-m19) : speed_t'(m19);
  endfunction

endpackage

>>> sv/lfv_delay.sv
module lfv_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [D];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(D); k++) begin
        tap_q[k] <= '0;
      end
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < int'(D); k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[D-1];

endmodule

>>> sv/lfv_isqrt.sv
module lfv_isqrt #(
  parameter int unsigned IW = 66
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [IW-1:0]   din_i,
  output logic [IW/2-1:0] dout_o
);

  localparam int unsigned RW = IW / 2;

  logic [IW-1:0] x_q   [RW];
  logic [IW-1:0] x_d   [RW];
  logic [RW+1:0] rem_q [RW];
  logic [RW+1:0] rem_d [RW];
  logic [RW-1:0] r_q   [RW];
  logic [RW-1:0] r_d   [RW];

  // one result bit per stage
  always_comb begin
    logic [IW-1:0] xs;
    logic [RW+1:0] ri;
    logic [RW-1:0] qi;
    logic [RW+2:0] rs;
    logic [RW+2:0] t;
    for (int k = 0; k < int'(RW); k++) begin
      if (k == 0) begin
        xs = din_i;
        ri = '0;
        qi = '0;
      end else begin
        xs = x_q[k-1];
        ri = rem_q[k-1];
        qi = r_q[k-1];
      end
      rs = {ri[RW:0], xs[IW-1 -: 2]};
      t  = {1'b0, qi, 2'b01};
      if (rs >= t) begin
        rem_d[k] = (RW+2)'(rs - t);
        r_d[k]   = {qi[RW-2:0], 1'b1};
      end else begin
        rem_d[k] = rs[RW+1:0];
        r_d[k]   = {qi[RW-2:0], 1'b0};
      end
      x_d[k] = {xs[IW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < int'(RW); k++) begin
        x_q[k]   <= x_d[k];
        rem_q[k] <= rem_d[k];
        r_q[k]   <= r_d[k];
      end
    end
  end

  assign dout_o = r_q[RW-1];

endmodule

>>> sv/lfv_div.sv
module lfv_div #(
  parameter int unsigned NW = 65,
  parameter int unsigned DW = 33
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0] n_q   [NW];
  logic [NW-1:0] n_d   [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] rem_d [NW];
  logic [DW-1:0] d_q   [NW];
  logic [DW-1:0] d_d   [NW];

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [NW-1:0] ns;
    logic [DW-1:0] ri;
    logic [DW-1:0] di;
    logic [DW:0]   rs;
    logic          qb;
    for (int k = 0; k < int'(NW); k++) begin
      if (k == 0) begin
        ns = num_i;
        ri = '0;
        di = den_i;
      end else begin
        ns = n_q[k-1];
        ri = rem_q[k-1];
        di = d_q[k-1];
      end
      rs = {ri, ns[NW-1]};
      qb = (rs >= {1'b0, di});
      if (qb) begin
        rem_d[k] = DW'(rs - {1'b0, di});
      end else begin
        rem_d[k] = rs[DW-1:0];
      end
      n_d[k] = {ns[NW-2:0], qb};
      d_d[k] = di;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < int'(NW); k++) begin
        n_q[k]   <= n_d[k];
        rem_q[k] <= rem_d[k];
        d_q[k]   <= d_d[k];
      end
    end
  end

  assign quo_o = n_q[NW-1];

endmodule

>>> sv/lfv_cordic.sv
module lfv_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] x_i,
  input  logic signed [32:0] y_i,
  output logic signed [15:0] z_o
);
  import lfv_pkg::*;

  localparam int unsigned XW = 36;
  localparam int unsigned NS = CORDIC_STEPS + 1;

  logic signed [XW-1:0] x_q [NS];
  logic signed [XW-1:0] x_d [NS];
  logic signed [XW-1:0] y_q [NS];
  logic signed [XW-1:0] y_d [NS];
  logic signed [15:0]   z_q [NS];
  logic signed [15:0]   z_d [NS];

  always_comb begin
    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    xe = XW'(x_i);
    ye = XW'(y_i);
    // left half plane: turn by a quarter first
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x_d[0] = ye;
        y_d[0] = -xe;
        z_d[0] = HALF_PI_Q13;
      end else begin
        x_d[0] = -ye;
        y_d[0] = xe;
        z_d[0] = -HALF_PI_Q13;
      end
    end else begin
      x_d[0] = xe;
      y_d[0] = ye;
      z_d[0] = '0;
    end
    for (int i = 0; i < int'(CORDIC_STEPS); i++) begin
      dx = x_q[i] >>> i;
      dy = y_q[i] >>> i;
      if (y_q[i] > 0) begin
        x_d[i+1] = x_q[i] + dy;
        y_d[i+1] = y_q[i] - dx;
        z_d[i+1] = z_q[i] + CORDIC_ANGLE[i];
      end else if (y_q[i] < 0) begin
        x_d[i+1] = x_q[i] - dy;
        y_d[i+1] = y_q[i] + dx;
        z_d[i+1] = z_q[i] - CORDIC_ANGLE[i];
      end else begin
        x_d[i+1] = x_q[i];
        y_d[i+1] = y_q[i];
        z_d[i+1] = z_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < int'(NS); k++) begin
        x_q[k] <= x_d[k];
        y_q[k] <= y_d[k];
        z_q[k] <= z_d[k];
      end
    end
  end

  assign z_o = z_q[NS-1];

endmodule

>>> sv/line_follow_velocity_law.sv
// throughput: one beat per cycle unless a valid output beat is stalled, set by the
// fully pipelined square root, divider and cordic stages; the longest chain is the
// line offset path (square root, 65 stage divide, square root)
// reset: pipeline empty, registers at their default limits
module line_follow_velocity_law (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   pose_x_i,
  input  logic signed [31:0]   pose_y_i,
  input  logic signed [15:0]   pose_heading_i,
  input  logic signed [31:0]   segment_start_x_i,
  input  logic signed [31:0]   segment_start_y_i,
  input  logic signed [31:0]   goal_x_i,
  input  logic signed [31:0]   goal_y_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lfv_pkg::speed_t      forward_speed_o,
  output lfv_pkg::speed_t      side_speed_o,
  output lfv_pkg::speed_t      turn_rate_o,
  output logic [31:0]          goal_distance_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [17:0]          cfg_data_i
);
  import lfv_pkg::*;

  localparam int unsigned SQ66_LAT   = 33;
  localparam int unsigned ROOT_LAT   = 24;
  localparam int unsigned DIV_LAT    = 65;
  localparam int unsigned OSQ_LAT    = 26;
  localparam int unsigned TDIV_LAT   = 3;
  localparam int unsigned TSQ_LAT    = 17;
  localparam int unsigned CORDIC_LAT = CORDIC_STEPS + 1;

  localparam int unsigned T_SUM  = 4;
  localparam int unsigned T_LEN  = T_SUM + SQ66_LAT;
  localparam int unsigned T_DIST = T_LEN + 1;
  localparam int unsigned T_ROOT = T_DIST + ROOT_LAT;
  localparam int unsigned T_FMAG = T_ROOT + 2;
  localparam int unsigned T_OFF  = T_LEN + DIV_LAT;
  localparam int unsigned T_OSQ  = T_OFF + 1;
  localparam int unsigned T_SMAG = T_OSQ + OSQ_LAT + 2;
  localparam int unsigned T_Z    = 1 + CORDIC_LAT;
  localparam int unsigned T_EMAG = T_Z + 2;
  localparam int unsigned T_Q    = T_EMAG + TDIV_LAT;
  localparam int unsigned T_TMAG = T_Q + 1 + TSQ_LAT + 2;
  localparam int unsigned T_OUT  = T_SMAG + 1;

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // configuration
  logic [REG_W-1:0] fwd_min_q, fwd_max_q, side_min_q, side_max_q, turn_min_q, turn_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_min_q  <= 18'd1311;
      fwd_max_q  <= 18'd52429;
      side_min_q <= 18'd655;
      side_max_q <= 18'd6554;
      turn_min_q <= 18'd3277;
      turn_max_q <= 18'd32768;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_FWD_MIN:  fwd_min_q  <= cfg_data_i;
        CFG_FWD_MAX:  fwd_max_q  <= cfg_data_i;
        CFG_SIDE_MIN: side_min_q <= cfg_data_i;
        CFG_SIDE_MAX: side_max_q <= cfg_data_i;
        CFG_TURN_MIN: turn_min_q <= cfg_data_i;
        CFG_TURN_MAX: turn_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lfv_delay #(.W(1), .D(T_OUT)) u_valid (
    .clk_i, .rst_ni, .en_i(en), .d_i(in_valid_i), .q_o(out_valid_o)
  );

  // stage 1: differences
  logic signed [32:0] dx_q, dy_q, ux_q, uy_q, wx_q, wy_q;
  logic signed [15:0] hd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= 33'(goal_x_i) - 33'(pose_x_i);
      dy_q <= 33'(goal_y_i) - 33'(pose_y_i);
      ux_q <= 33'(goal_x_i) - 33'(segment_start_x_i);
      uy_q <= 33'(goal_y_i) - 33'(segment_start_y_i);
      wx_q <= 33'(pose_x_i) - 33'(segment_start_x_i);
      wy_q <= 33'(pose_y_i) - 33'(segment_start_y_i);
      hd_q <= pose_heading_i;
    end
  end

  // stage 2: magnitudes
  logic [31:0] adx_q, ady_q, aux_q, auy_q, awx_q, awy_q;
  logic        n1_q, n2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      adx_q <= 32'(dx_q[32] ? -dx_q : dx_q);
      ady_q <= 32'(dy_q[32] ? -dy_q : dy_q);
      aux_q <= 32'(ux_q[32] ? -ux_q : ux_q);
      auy_q <= 32'(uy_q[32] ? -uy_q : uy_q);
      awx_q <= 32'(wx_q[32] ? -wx_q : wx_q);
      awy_q <= 32'(wy_q[32] ? -wy_q : wy_q);
      n1_q  <= wx_q[32] != uy_q[32];
      n2_q  <= !(wy_q[32] != ux_q[32]);
    end
  end

  // stage 3: products
  logic [63:0] pdx_q, pdy_q, pux_q, puy_q, m1_q, m2_q;
  logic        n1p_q, n2p_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pdx_q <= 64'(adx_q) * 64'(adx_q);
      pdy_q <= 64'(ady_q) * 64'(ady_q);
      pux_q <= 64'(aux_q) * 64'(aux_q);
      puy_q <= 64'(auy_q) * 64'(auy_q);
      m1_q  <= 64'(awx_q) * 64'(auy_q);
      m2_q  <= 64'(awy_q) * 64'(aux_q);
      n1p_q <= n1_q;
      n2p_q <= n2_q;
    end
  end

  // stage 4: sums and the cross product
  logic [64:0] dsum_q, lsum_q, c_q, c_d;
  logic        cneg_q, cneg_d;

  always_comb begin
    logic n1e;
    logic n2e;
    n1e = n1p_q && (m1_q != '0);
    n2e = n2p_q && (m2_q != '0);
    if (n1e == n2e) begin
      c_d    = {1'b0, m1_q} + {1'b0, m2_q};
      cneg_d = n1e;
    end else if (m1_q >= m2_q) begin
      c_d    = {1'b0, m1_q - m2_q};
      cneg_d = n1e;
    end else begin
      c_d    = {1'b0, m2_q - m1_q};
      cneg_d = n2e;
    end
    if (c_d == '0) begin
      cneg_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsum_q <= {1'b0, pdx_q} + {1'b0, pdy_q};
      lsum_q <= {1'b0, pux_q} + {1'b0, puy_q};
      c_q    <= c_d;
      cneg_q <= cneg_d;
    end
  end

  // distance and segment length
  logic [32:0] dist_raw, len;

  lfv_isqrt #(.IW(2 * SQ66_LAT)) u_dist_sqrt (
    .clk_i, .en_i(en), .din_i({1'b0, dsum_q}), .dout_o(dist_raw)
  );

  lfv_isqrt #(.IW(2 * SQ66_LAT)) u_len_sqrt (
    .clk_i, .en_i(en), .din_i({1'b0, lsum_q}), .dout_o(len)
  );

  // forward path
  logic [31:0] dist_q;
  logic        far_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dist_raw[32] ? 32'hFFFF_FFFF : dist_raw[31:0];
      far_q  <= (dist_raw[32] ? 32'hFFFF_FFFF : dist_raw[31:0]) > NEAR_LIMIT;
    end
  end

  logic [ROOT_LAT-1:0] froot;
  logic                far_r;

  lfv_isqrt #(.IW(2 * ROOT_LAT)) u_fwd_sqrt (
    .clk_i, .en_i(en), .din_i({dist_q, 16'h0000}), .dout_o(froot)
  );

  lfv_delay #(.W(1), .D(T_ROOT - T_DIST)) u_far_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(far_q), .q_o(far_r)
  );

  logic [57:0]      fprod_q;
  logic [MAG_W-1:0] fmag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fprod_q <= 58'(far_r ? {froot, 2'b00} : {1'b0, froot, 1'b0}) * 58'(RECIP_5);
      fmag_q  <= MAG_W'(fprod_q >> RECIP_5_SH);
    end
  end

  // line offset path
  logic [64:0] c_l;
  logic        cneg_o, len0_o;
  logic [64:0] off_q;

  lfv_delay #(.W(65), .D(T_LEN - T_SUM)) u_c_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(c_q), .q_o(c_l)
  );

  lfv_delay #(.W(1), .D(T_OFF - T_SUM)) u_cneg_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(cneg_q), .q_o(cneg_o)
  );

  lfv_delay #(.W(1), .D(T_OFF - T_LEN)) u_len0_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(len == '0), .q_o(len0_o)
  );

  lfv_div #(.NW(DIV_LAT), .DW(33)) u_off_div (
    .clk_i, .en_i(en), .num_i(c_l), .den_i(len), .quo_o(off_q)
  );

  logic [2*OSQ_LAT-1:0] osq_q;
  logic                 sneg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      osq_q  <= len0_o ? '0 : {1'b0, off_q[34:0], 16'h0000};
      sneg_q <= cneg_o && !len0_o;
    end
  end

  logic [OSQ_LAT-1:0] sroot;
  logic [58:0]        sprod_q;
  logic [MAG_W-1:0]   smag_q;

  lfv_isqrt #(.IW(2 * OSQ_LAT)) u_side_sqrt (
    .clk_i, .en_i(en), .din_i(osq_q), .dout_o(sroot)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sprod_q <= 59'({sroot, 1'b0}) * 59'(RECIP_25);
      smag_q  <= MAG_W'(sprod_q >> RECIP_25_SH);
    end
  end

  // heading path
  logic signed [15:0] bearing, hd_z;

  lfv_cordic u_cordic (
    .clk_i, .en_i(en), .x_i(dx_q), .y_i(dy_q), .z_o(bearing)
  );

  lfv_delay #(.W(16), .D(T_Z - 1)) u_hd_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(hd_q), .q_o(hd_z)
  );

  logic signed [17:0] e_q, e_d;
  logic [14:0]        emag_q;
  logic               eneg_q, fneg_q, big_q;

  always_comb begin
    e_d = 18'(bearing) - 18'(hd_z);
    if (e_d > PI_Q13) begin
      e_d = e_d - TWO_PI_Q13;
    end else if (e_d <= -PI_Q13) begin
      e_d = e_d + TWO_PI_Q13;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q    <= e_d;
      emag_q <= 15'(e_q[17] ? -e_q : e_q);
      eneg_q <= e_q[17];
      fneg_q <= !(15'(e_q[17] ? -e_q : e_q) < HALF_PI_MAG);
      big_q  <= 15'(e_q[17] ? -e_q : e_q) > TURN_THRESH;
    end
  end

  // |e| * 2^32 / pi by constant multiplies over three stages
  logic [32:0] tp1_q, tp2_q, tq_q;
  logic [25:0] tx_q;
  logic [52:0] ty_q;
  logic        big_r;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tp1_q <= 33'(emag_q) * 33'(TURN_MUL_HI);
      tx_q  <= 26'(emag_q) * 26'(TURN_MUL_LO);
      tp2_q <= tp1_q;
      ty_q  <= 53'(tx_q) * 53'(RECIP_3217);
      tq_q  <= tp2_q + 33'(ty_q >> RECIP_3217_SH);
    end
  end

  lfv_delay #(.W(1), .D(T_Q - T_EMAG)) u_big_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(big_q), .q_o(big_r)
  );

  logic [2*TSQ_LAT-1:0] tin_q;
  logic [TSQ_LAT-1:0]   troot;
  logic [49:0]          tprod_q;
  logic [MAG_W-1:0]     tmag_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tin_q <= big_r ? {1'b0, tq_q} : '0;
    end
  end

  lfv_isqrt #(.IW(2 * TSQ_LAT)) u_turn_sqrt (
    .clk_i, .en_i(en), .din_i(tin_q), .dout_o(troot)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      tprod_q <= 50'({troot, 1'b0}) * 50'(RECIP_5);
      tmag_q  <= MAG_W'(tprod_q >> RECIP_5_SH);
    end
  end

  // alignment to the output stage
  logic [MAG_W-1:0] fmag_a, tmag_a;
  logic [31:0]      dist_a;
  logic             fneg_a, eneg_a, sneg_a;

  lfv_delay #(.W(MAG_W), .D(T_SMAG - T_FMAG)) u_fmag_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(fmag_q), .q_o(fmag_a)
  );

  lfv_delay #(.W(MAG_W), .D(T_SMAG - T_TMAG)) u_tmag_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(tmag_q), .q_o(tmag_a)
  );

  lfv_delay #(.W(32), .D(T_SMAG - T_DIST)) u_dist_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(dist_q), .q_o(dist_a)
  );

  lfv_delay #(.W(2), .D(T_SMAG - T_EMAG)) u_sign_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i({fneg_q, eneg_q}), .q_o({fneg_a, eneg_a})
  );

  lfv_delay #(.W(1), .D(T_SMAG - T_OSQ)) u_sneg_dly (
    .clk_i, .rst_ni, .en_i(en), .d_i(sneg_q), .q_o(sneg_a)
  );

  // output register
  speed_t      fwd_q, side_q, turn_q;
  logic [31:0] gdist_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_q   <= lfv_limit(fmag_a, fneg_a, fwd_min_q, fwd_max_q);
      side_q  <= lfv_limit(smag_q, sneg_a, side_min_q, side_max_q);
      turn_q  <= lfv_limit(tmag_a, eneg_a, turn_min_q, turn_max_q);
      gdist_q <= dist_a;
    end
  end

  assign forward_speed_o = fwd_q;
  assign side_speed_o    = side_q;
  assign turn_rate_o     = turn_q;
  assign goal_distance_o = gdist_q;

endmodule
